>>> sv/hefc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater energy frame controller package
// Shared types, constants and register addresses.
// ----------------------------------------------------------------------------
package hefc_pkg;

    localparam int FRAME_TICKS = 102;
    localparam int TICK_W      = 7;
    localparam int AW          = 5;

    localparam logic [AW-1:0] ADDR_DRIVE_MODE   = 5'h00;
    localparam logic [AW-1:0] ADDR_TARGET       = 5'h04;
    localparam logic [AW-1:0] ADDR_LOW_BATTERY  = 5'h08;
    localparam logic [AW-1:0] ADDR_PUFF_DEB     = 5'h0C;
    localparam logic [AW-1:0] ADDR_DETECT_DEB   = 5'h10;

    // Drive modes held in the mode register.
    localparam logic [1:0] MODE_ONE  = 2'd0;
    localparam logic [1:0] MODE_TWO  = 2'd1;
    localparam logic [1:0] MODE_ALT  = 2'd2;
    localparam logic [1:0] MODE_BOTH = 2'd3;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_HEATING = 3'd1;
    localparam logic [2:0] ST_LOW_BAT = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_OPEN    = 3'd4;

    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_ONE_IN   = 4'd1;
    localparam logic [3:0] EV_ONE_OUT  = 4'd2;
    localparam logic [3:0] EV_TWO_IN   = 4'd3;
    localparam logic [3:0] EV_TWO_OUT  = 4'd4;
    localparam logic [3:0] EV_CAL      = 4'd5;
    localparam logic [3:0] EV_REACHED  = 4'd6;
    localparam logic [3:0] EV_MISSED   = 4'd7;
    localparam logic [3:0] EV_BAT_LOW  = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE, S_SQUARE, S_DIVIDE, S_ACCUM, S_FINISH, S_OUT
    } state_t;

    typedef struct packed {
        logic        puff_active;
        logic        detect_one_pin;
        logic        detect_two_pin;
        logic [15:0] heater_one_mv;
        logic [15:0] heater_two_mv;
        logic [15:0] battery_mv;
        logic [15:0] heater_one_res;
        logic [15:0] heater_two_res;
        logic        channels_ready;
    } in_item_t;

    typedef struct packed {
        logic       drive_one;
        logic       drive_two;
        logic       sample_trigger;
        logic [2:0] device_status;
        logic [3:0] first_event;
        logic [3:0] second_event;
    } out_item_t;

endpackage

>>> sv/heater_energy_frame_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater energy frame controller
// Per-tick heater control with serial V*V/R energy accumulation.
// ----------------------------------------------------------------------------
// One input beat is one 100 us tick; each tick gives exactly one result beat.
// A tick that does no energy work passes through the accept cycle, a
// dispatch cycle, a finish cycle and the result cycle. A heating tick from
// the third to the second-last of a frame, until the target is met,
// squares and divides each selected heater voltage on one shared
// bit-serial unit: a load step, a shift-and-add squaring and a restoring
// division per heater. That shared serial unit sets the rate, and a
// receiver that holds off a result slows it further. A new beat is taken
// only after the previous result beat has been delivered. Configuration
// is through an APB-style port at byte addresses 0, 4, 8, 12 and 16.
module heater_energy_frame_controller
    import hefc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  in_item_t        in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output out_item_t       out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [AW-1:0]   paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    // Configuration registers.
    logic [1:0]  drive_mode_reg;
    logic [31:0] target_reg;
    logic [15:0] low_bat_reg;
    logic [7:0]  puff_deb_reg;
    logic [12:0] det_deb_reg;

    // Control state.
    state_t          state_reg, state_next;
    in_item_t        item_reg;
    out_item_t       out_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [31:0]     energy_reg;
    logic            met_reg, bat_seen_reg, short_reg, alt_reg;
    logic [7:0]      puff_reg;
    logic [1:0]      present_reg, ins_decl_reg, rem_decl_reg;
    logic [12:0]     ins_cnt_reg [2];
    logic [12:0]     rem_cnt_reg [2];
    logic [2:0]      status_reg;
    logic [1:0]      drives_reg;

    // Serial arithmetic unit and per-tick working state.
    logic [1:0]      sel_reg;        // heaters used this tick
    logic [1:0]      todo_reg;       // heaters whose power is still owed
    logic [5:0]      cnt_reg;
    logic [31:0]     prod_reg;       // square, then quotient
    logic [15:0]     mcand_reg;
    logic [15:0]     mplier_reg;
    logic [16:0]     rem_reg;
    logic [15:0]     div_reg;
    logic [32:0]     sum_reg;        // bit 32 flags a sum still to be resolved
    logic [3:0]      ev0_reg, ev1_reg;
    logic [1:0]      evn_reg;
    logic            trig_reg;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            ADDR_DRIVE_MODE:  prdata = {30'd0, drive_mode_reg};
            ADDR_TARGET:      prdata = target_reg;
            ADDR_LOW_BATTERY: prdata = {16'd0, low_bat_reg};
            ADDR_PUFF_DEB:    prdata = {24'd0, puff_deb_reg};
            ADDR_DETECT_DEB:  prdata = {19'd0, det_deb_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_mode_reg <= MODE_ALT;
            target_reg     <= 32'd500000;
            low_bat_reg    <= 16'd3600;
            puff_deb_reg   <= 8'd200;
            det_deb_reg    <= 13'd5000;
        end
        else if (cfg_write)
        begin
            case (paddr)
                ADDR_DRIVE_MODE:  drive_mode_reg <= pwdata[1:0];
                ADDR_TARGET:      target_reg     <= pwdata;
                ADDR_LOW_BATTERY: low_bat_reg    <= pwdata[15:0];
                ADDR_PUFF_DEB:    puff_deb_reg   <= pwdata[7:0];
                ADDR_DETECT_DEB:  det_deb_reg    <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_ACCUM;
            S_ACCUM:  state_next = (todo_reg == 2'b00) ? S_FINISH : S_SQUARE;
            S_SQUARE: if (cnt_reg == 6'd1) state_next = S_DIVIDE;
            S_DIVIDE:
            begin
                if (cnt_reg == 6'd1)
                    state_next = (todo_reg == 2'b00) ? S_FINISH : S_ACCUM;
            end
            S_FINISH: state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // The tick is worked in one clocked block; most of the tick's control is
    // decided in the accept cycle, the energy path afterwards.
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [3:0]  e0, e1;
        logic [1:0]  en;
        logic        tr, run;
        logic [1:0]  sel, dr;
        logic [2:0]  st;
        logic [7:0]  pc;
        logic        alt, sh, bs, met;
        logic [TICK_W-1:0] tk;
        logic [31:0] en_e;
        logic [1:0]  pres, idec, rdec;
        logic [12:0] ic [2];
        logic [12:0] rc [2];
        logic        pin;
        logic [16:0] trial;
        logic [32:0] acc;
        if (!rst_n)
        begin
            tick_reg     <= '0;
            energy_reg   <= '0;
            met_reg      <= 1'b0;
            bat_seen_reg <= 1'b0;
            short_reg    <= 1'b0;
            alt_reg      <= 1'b0;
            puff_reg     <= '0;
            present_reg  <= '0;
            ins_decl_reg <= '0;
            rem_decl_reg <= '0;
            ins_cnt_reg  <= '{default: '0};
            rem_cnt_reg  <= '{default: '0};
            status_reg   <= ST_IDLE;
            drives_reg   <= '0;
            todo_reg     <= '0;
            sel_reg      <= '0;
            cnt_reg      <= '0;
            ev0_reg      <= EV_NONE;
            ev1_reg      <= EV_NONE;
            evn_reg      <= '0;
            trig_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        e0 = EV_NONE; e1 = EV_NONE; en = 2'd0; tr = 1'b0;
                        run = 1'b0; sel = 2'd0;
                        dr = drives_reg; st = status_reg; pc = puff_reg;
                        alt = alt_reg; sh = short_reg; bs = bat_seen_reg;
                        met = met_reg; tk = tick_reg; en_e = energy_reg;
                        pres = present_reg; idec = ins_decl_reg;
                        rdec = rem_decl_reg;
                        ic = ins_cnt_reg; rc = rem_cnt_reg;
                        if (in_data.puff_active)
                        begin
                            if (pc != 8'd255)
                            begin
                                pc = pc + 8'd1;
                                if (pc == puff_deb_reg)
                                begin
                                    e0 = EV_CAL; en = 2'd1; alt = ~alt;
                                end
                            end
                            if (in_data.channels_ready && !sh)
                            begin
                                st = ST_HEATING;
                                case (drive_mode_reg)
                                    MODE_ONE: sel = pres[0] ? 2'b01 : 2'b00;
                                    MODE_TWO: sel = pres[1] ? 2'b10 : 2'b00;
                                    MODE_ALT: sel = alt ? (pres[0] ? 2'b01 : 2'b00)
                                                        : (pres[1] ? 2'b10 : 2'b00);
                                    default: sel = (pres == 2'b11) ? 2'b11 : 2'b00;
                                endcase
                                if (sel != 2'b00)
                                begin
                                    if (tk == TICK_W'(FRAME_TICKS))
                                        tk = '0;
                                    tk = tk + 1'b1;
                                    if (tk == TICK_W'(1))
                                    begin
                                        dr = 2'b00; tr = 1'b1; met = 1'b0;
                                        en_e = '0;
                                    end
                                    if (!met)
                                    begin
                                        if (tk == TICK_W'(2))
                                        begin
                                            if (in_data.battery_mv < low_bat_reg)
                                            begin
                                                dr = 2'b00; tk = '0;
                                                if (!bs)
                                                begin
                                                    bs = 1'b1; st = ST_LOW_BAT;
                                                    if (en == 2'd0) e0 = EV_BAT_LOW;
                                                    else e1 = EV_BAT_LOW;
                                                    en = en + 2'd1;
                                                end
                                            end
                                            else
                                            begin
                                                dr = sel; tr = 1'b1;
                                            end
                                        end
                                        else if (tk >= TICK_W'(3) &&
                                                 tk < TICK_W'(FRAME_TICKS))
                                            run = 1'b1;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            st = ST_IDLE; tk = '0; pc = '0; sh = 1'b0;
                            bs = 1'b0; dr = 2'b00;
                            for (int h = 0; h < 2; h++)
                            begin
                                pin = h[0] ? in_data.detect_two_pin
                                           : in_data.detect_one_pin;
                                if (!pin)
                                begin
                                    if (!idec[h])
                                    begin
                                        ic[h] = ic[h] + 13'd1;
                                        if (ic[h] == det_deb_reg)
                                        begin
                                            idec[h] = 1'b1; rdec[h] = 1'b0;
                                            ic[h] = '0; pres[h] = 1'b1;
                                            if (en == 2'd0)
                                                e0 = h[0] ? EV_TWO_IN : EV_ONE_IN;
                                            else
                                                e1 = h[0] ? EV_TWO_IN : EV_ONE_IN;
                                            en = en + 2'd1;
                                        end
                                    end
                                end
                                else if (!rdec[h])
                                begin
                                    rc[h] = rc[h] + 13'd1;
                                    if (rc[h] == det_deb_reg)
                                    begin
                                        idec[h] = 1'b0; rdec[h] = 1'b1;
                                        rc[h] = '0; pres[h] = 1'b0;
                                        st = ST_OPEN;
                                        if (en == 2'd0)
                                            e0 = h[0] ? EV_TWO_OUT : EV_ONE_OUT;
                                        else
                                            e1 = h[0] ? EV_TWO_OUT : EV_ONE_OUT;
                                        en = en + 2'd1;
                                    end
                                end
                            end
                        end
                        ev0_reg <= e0; ev1_reg <= e1; evn_reg <= en;
                        trig_reg <= tr; drives_reg <= dr; status_reg <= st;
                        puff_reg <= pc; alt_reg <= alt; short_reg <= sh;
                        bat_seen_reg <= bs; met_reg <= met; tick_reg <= tk;
                        energy_reg <= en_e; present_reg <= pres;
                        ins_decl_reg <= idec; rem_decl_reg <= rdec;
                        ins_cnt_reg <= ic; rem_cnt_reg <= rc;
                        sel_reg <= sel;
                        todo_reg <= run ? sel : 2'b00;
                        sum_reg <= {1'b0, en_e};
                    end
                end
                S_ACCUM:
                begin
                    // Pick the next owed heater and load the squarer.
                    if (todo_reg != 2'b00)
                    begin
                        todo_reg   <= todo_reg[0] ? {todo_reg[1], 1'b0} : 2'b00;
                        mcand_reg  <= todo_reg[0] ? item_reg.heater_one_mv
                                                  : item_reg.heater_two_mv;
                        mplier_reg <= todo_reg[0] ? item_reg.heater_one_mv
                                                  : item_reg.heater_two_mv;
                        div_reg    <= todo_reg[0] ? item_reg.heater_one_res
                                                  : item_reg.heater_two_res;
                        prod_reg   <= '0;
                        cnt_reg    <= 6'd16;
                    end
                end
                S_SQUARE:
                begin
                    // Shift-and-add, multiplier bit taken from the top.
                    prod_reg <= {prod_reg[30:0], 1'b0} +
                                (mplier_reg[15] ? {16'd0, mcand_reg} : 32'd0);
                    mplier_reg <= {mplier_reg[14:0], 1'b0};
                    if (cnt_reg == 6'd1)
                    begin
                        cnt_reg <= 6'd32;
                        rem_reg <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                S_DIVIDE:
                begin
                    // Restoring division, one quotient bit a cycle.
                    trial = {rem_reg[15:0], prod_reg[31]};
                    if (trial >= {1'b0, div_reg})
                    begin
                        rem_reg  <= trial - {1'b0, div_reg};
                        prod_reg <= {prod_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= trial;
                        prod_reg <= {prod_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                end
                S_FINISH:
                begin
                    // A frame tick resolves its summed energy here: compare with the target,
                    // then stop, or drive and check for a short; every tick's result is built here.
                    e0 = ev0_reg; e1 = ev1_reg; en = evn_reg;
                    dr = drives_reg; st = status_reg; tr = trig_reg;
                    met = met_reg; sh = short_reg;
                    if (tick_reg >= TICK_W'(3) && tick_reg < TICK_W'(FRAME_TICKS)
                        && sum_reg[32])
                    begin
                        en_e = sum_reg[31:0];
                        energy_reg <= en_e;
                        sum_reg[32] <= 1'b0;
                        if (en_e >= target_reg)
                        begin
                            dr = 2'b00; met = 1'b1;
                            if (en == 2'd0) e0 = EV_REACHED;
                            else if (en == 2'd1) e1 = EV_REACHED;
                        end
                        else
                        begin
                            if (tick_reg == TICK_W'(FRAME_TICKS - 1))
                            begin
                                if (en == 2'd0) e0 = EV_MISSED;
                                else if (en == 2'd1) e1 = EV_MISSED;
                            end
                            dr = sel_reg; tr = 1'b1;
                            if ((sel_reg[0] && !item_reg.detect_one_pin) ||
                                (sel_reg[1] && !item_reg.detect_two_pin))
                            begin
                                dr = 2'b00; sh = 1'b1; st = ST_SHORT;
                            end
                        end
                        drives_reg <= dr; status_reg <= st; met_reg <= met;
                        short_reg <= sh;
                    end
                    out_reg <= '{drive_one: dr[0], drive_two: dr[1],
                                 sample_trigger: tr, device_status: st,
                                 first_event: e0, second_event: e1};
                end
                default: ;
            endcase

            // Accumulate each quotient as the divider completes (a zero code
            // gives zero power); the flag bit 32 marks a sum to be resolved.
            if (state_reg == S_DIVIDE && cnt_reg == 6'd1)
            begin
                trial = {rem_reg[15:0], prod_reg[31]};
                acc = {1'b0, sum_reg[31:0]} + (div_reg == 16'd0 ? 33'd0 :
                      {1'b0, prod_reg[30:0], (trial >= {1'b0, div_reg})});
                if (acc[32])
                    acc = {1'b0, 32'hFFFF_FFFF};
                sum_reg <= {1'b1, acc[31:0]};
            end
        end
    end

    // A result beat only appears after the accept cycle has been worked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result beat in the accept cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= TICK_W'(FRAME_TICKS))
        else $error("frame tick beyond frame length");

endmodule

>>> tb/tb_heater_energy_frame_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater energy frame controller testbench
// Drives tick beats through the block, with register settings changed between
// phases over the APB port. Every result beat is checked against a predictor
// of the controller kept inside this bench, or against a typed expected beat.
// ----------------------------------------------------------------------------
module tb_heater_energy_frame_controller;
    import hefc_pkg::*;

    localparam int ITEM_GOAL  = 1950;
    localparam int CYCLE_CAP  = 3000000;
    localparam int LONG_HOLD  = 400;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    in_item_t        in_data;
    logic            out_valid;
    logic            out_ready;
    out_item_t       out_data;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [AW-1:0]   paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    heater_energy_frame_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state. The register copies are updated whenever the bench
    // writes a register, and the frame state follows each accepted tick.
    // ------------------------------------------------------------------------
    logic [1:0]  cfg_mode;
    logic [31:0] cfg_target;
    logic [15:0] cfg_low_bat;
    logic [7:0]  cfg_puff_deb;
    logic [12:0] cfg_detect_deb;

    logic [6:0]  frame_pos;
    logic [31:0] frame_sum;
    logic        frame_done;
    logic        low_bat_flagged;
    logic        short_latched;
    logic        alt_pick;
    logic [7:0]  puff_ticks;
    logic        present [2];
    logic        in_seen [2];
    logic        out_seen [2];
    logic [12:0] in_run [2];
    logic [12:0] out_run [2];
    logic [2:0]  status_now;
    logic [1:0]  drives_now;

    logic [3:0]  tick_events [2];
    int          tick_event_cnt;
    logic        tick_trig;

    out_item_t   due_outputs [$];
    int          mismatches = 0;
    int          checked = 0;
    int          reached_seen = 0;
    int          cal_seen = 0;
    int          items_sent;
    int          cycles = 0;
    bit          no_idle;
    bit          long_hold_req;

    task automatic predictor_reset();
        cfg_mode        = MODE_ALT;
        cfg_target      = 32'd500000;
        cfg_low_bat     = 16'd3600;
        cfg_puff_deb    = 8'd200;
        cfg_detect_deb  = 13'd5000;
        frame_pos       = '0;
        frame_sum       = '0;
        frame_done      = 1'b0;
        low_bat_flagged = 1'b0;
        short_latched   = 1'b0;
        alt_pick        = 1'b0;
        puff_ticks      = '0;
        for (int h = 0; h < 2; h++)
        begin
            present[h]  = 1'b0;
            in_seen[h]  = 1'b0;
            out_seen[h] = 1'b0;
            in_run[h]   = '0;
            out_run[h]  = '0;
        end
        status_now = ST_IDLE;
        drives_now = 2'b00;
    endtask

    // Only two events fit in one result beat; later ones are dropped.
    function automatic void post_event(logic [3:0] ev);
        if (tick_event_cnt < 2)
        begin
            tick_events[tick_event_cnt] = ev;
            tick_event_cnt++;
        end
    endfunction

    function automatic logic [31:0] heater_power(logic [15:0] mv, logic [15:0] res);
        logic [31:0] sq;
        if (res == 16'd0)
            return 32'd0;
        sq = 32'(mv) * 32'(mv);
        return sq / 32'(res);
    endfunction

    // Insertion and removal debounce of one heater, run on idle ticks only.
    function automatic void debounce_pin(int h, logic pin);
        if (pin == 1'b0)
        begin
            if (!in_seen[h])
            begin
                in_run[h] = in_run[h] + 13'd1;
                if (in_run[h] == cfg_detect_deb)
                begin
                    in_seen[h]  = 1'b1;
                    out_seen[h] = 1'b0;
                    in_run[h]   = '0;
                    present[h]  = 1'b1;
                    post_event(h ? EV_TWO_IN : EV_ONE_IN);
                end
            end
        end
        else
        begin
            if (!out_seen[h])
            begin
                out_run[h] = out_run[h] + 13'd1;
                if (out_run[h] == cfg_detect_deb)
                begin
                    in_seen[h]  = 1'b0;
                    out_seen[h] = 1'b1;
                    out_run[h]  = '0;
                    present[h]  = 1'b0;
                    status_now  = ST_OPEN;
                    post_event(h ? EV_TWO_OUT : EV_ONE_OUT);
                end
            end
        end
    endfunction

    // One tick of a heating frame; sel bit 0 is heater one, bit 1 heater two.
    function automatic void frame_step(logic [1:0] sel, in_item_t t);
        logic [32:0] sum;
        if (frame_pos == 7'(FRAME_TICKS))
            frame_pos = '0;
        frame_pos = frame_pos + 7'd1;
        if (frame_pos == 7'd1)
        begin
            drives_now = 2'b00;
            tick_trig  = 1'b1;
            frame_done = 1'b0;
            frame_sum  = '0;
        end
        if (frame_done)
            return;
        if (frame_pos == 7'd2)
        begin
            if (t.battery_mv < cfg_low_bat)
            begin
                // Low battery restarts the frame; flagged once per puff.
                drives_now = 2'b00;
                frame_pos  = '0;
                if (!low_bat_flagged)
                begin
                    low_bat_flagged = 1'b1;
                    status_now      = ST_LOW_BAT;
                    post_event(EV_BAT_LOW);
                end
                return;
            end
            drives_now = sel;
            tick_trig  = 1'b1;
        end
        if (frame_pos >= 7'd3 && frame_pos < 7'(FRAME_TICKS))
        begin
            sum = 33'(frame_sum);
            if (sel[0])
                sum += 33'(heater_power(t.heater_one_mv, t.heater_one_res));
            if (sel[1])
                sum += 33'(heater_power(t.heater_two_mv, t.heater_two_res));
            frame_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (frame_sum >= cfg_target)
            begin
                drives_now = 2'b00;
                post_event(EV_REACHED);
                frame_done = 1'b1;
                return;
            end
            if (frame_pos == 7'(FRAME_TICKS - 1))
                post_event(EV_MISSED);
            drives_now = sel;
            tick_trig  = 1'b1;
            // A detect pin pulled low on a driven heater means a short.
            if ((sel[0] && !t.detect_one_pin) || (sel[1] && !t.detect_two_pin))
            begin
                drives_now    = 2'b00;
                short_latched = 1'b1;
                status_now    = ST_SHORT;
            end
        end
    endfunction

    function automatic out_item_t predict_heater_tick(in_item_t t);
        out_item_t r;
        tick_events[0] = EV_NONE;
        tick_events[1] = EV_NONE;
        tick_event_cnt = 0;
        tick_trig      = 1'b0;
        if (t.puff_active)
        begin
            if (puff_ticks != 8'd255)
            begin
                puff_ticks++;
                if (puff_ticks == cfg_puff_deb)
                begin
                    post_event(EV_CAL);
                    alt_pick = !alt_pick;
                end
            end
            if (t.channels_ready && !short_latched)
            begin
                status_now = ST_HEATING;
                case (cfg_mode)
                    MODE_ONE:
                        if (present[0]) frame_step(2'b01, t);
                    MODE_TWO:
                        if (present[1]) frame_step(2'b10, t);
                    MODE_ALT:
                    begin
                        if (alt_pick)
                        begin
                            if (present[0]) frame_step(2'b01, t);
                        end
                        else if (present[1])
                            frame_step(2'b10, t);
                    end
                    default:
                        if (present[0] && present[1]) frame_step(2'b11, t);
                endcase
            end
        end
        else
        begin
            status_now      = ST_IDLE;
            frame_pos       = '0;
            puff_ticks      = '0;
            short_latched   = 1'b0;
            low_bat_flagged = 1'b0;
            drives_now      = 2'b00;
            debounce_pin(0, t.detect_one_pin);
            debounce_pin(1, t.detect_two_pin);
        end
        r.drive_one      = drives_now[0];
        r.drive_two      = drives_now[1];
        r.sample_trigger = tick_trig;
        r.device_status  = status_now;
        r.first_event    = tick_events[0];
        r.second_event   = tick_events[1];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and the cycle limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_outputs.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: checks each beat against the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 checked, field, got, want);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_outputs.size() == 0)
                report_mismatch("unexpected beat, queue size", 1, 0);
            else
            begin
                want = due_outputs.pop_front();
                if (out_data.drive_one != want.drive_one)
                    report_mismatch("drive_one", out_data.drive_one, want.drive_one);
                if (out_data.drive_two != want.drive_two)
                    report_mismatch("drive_two", out_data.drive_two, want.drive_two);
                if (out_data.sample_trigger != want.sample_trigger)
                    report_mismatch("sample_trigger", out_data.sample_trigger,
                                    want.sample_trigger);
                if (out_data.device_status != want.device_status)
                    report_mismatch("device_status", out_data.device_status,
                                    want.device_status);
                if (out_data.first_event != want.first_event)
                    report_mismatch("first_event", out_data.first_event,
                                    want.first_event);
                if (out_data.second_event != want.second_event)
                    report_mismatch("second_event", out_data.second_event,
                                    want.second_event);
                if (want.first_event == EV_REACHED || want.second_event == EV_REACHED)
                    reached_seen++;
                if (want.first_event == EV_CAL)
                    cal_seen++;
                checked++;
            end
        end
    end

    // The receiver stalls a random number of cycles before each beat. On
    // request it holds off for a long stretch so that the block backs up and
    // stops taking ticks while the sender keeps offering one.
    initial
    begin
        int wait_cycles;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(posedge clk);
                long_hold_req = 1'b0;
            end
            wait_cycles = no_idle ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Tick side.
    // ------------------------------------------------------------------------
    // Offers one tick beat after a random gap. Valid is only lowered when a
    // gap follows, so back-to-back beats keep it high.
    task automatic send_tick(in_item_t t, bit typed, out_item_t typed_want);
        int gap;
        out_item_t want;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        want = predict_heater_tick(t);
        due_outputs.push_back(typed ? typed_want : want);
        items_sent++;
    endtask

    // Waits until every expected beat has come back, then a few more cycles
    // so the block is idle before a register is touched.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [AW-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (addr)
            ADDR_DRIVE_MODE:  cfg_mode       = value[1:0];
            ADDR_TARGET:      cfg_target     = value;
            ADDR_LOW_BATTERY: cfg_low_bat    = value[15:0];
            ADDR_PUFF_DEB:    cfg_puff_deb   = value[7:0];
            default:          cfg_detect_deb = value[12:0];
        endcase
    endtask

    task automatic write_all(logic [1:0] mode, logic [31:0] target, logic [15:0] low_bat,
                             logic [7:0] puff_deb, logic [12:0] det_deb);
        write_reg(ADDR_DRIVE_MODE, 32'(mode));
        write_reg(ADDR_TARGET, target);
        write_reg(ADDR_LOW_BATTERY, 32'(low_bat));
        write_reg(ADDR_PUFF_DEB, 32'(puff_deb));
        write_reg(ADDR_DETECT_DEB, 32'(det_deb));
    endtask

    // A tick with random analogue samples. Resistance codes are biased
    // towards small values so that frames do reach their target, with the
    // occasional zero code.
    function automatic in_item_t make_tick(logic puff, logic ready, logic pin1, logic pin2);
        in_item_t t;
        t.puff_active    = puff;
        t.detect_one_pin = pin1;
        t.detect_two_pin = pin2;
        t.channels_ready = ready;
        t.heater_one_mv  = 16'($urandom);
        t.heater_two_mv  = 16'($urandom);
        t.heater_one_res = ($urandom_range(0, 19) == 0) ? 16'd0 :
                           ($urandom_range(0, 1) ? 16'($urandom_range(1, 4000))
                                                 : 16'($urandom));
        t.heater_two_res = ($urandom_range(0, 19) == 0) ? 16'd0 :
                           ($urandom_range(0, 1) ? 16'($urandom_range(1, 4000))
                                                 : 16'($urandom));
        if ($urandom_range(0, 9) == 0)
            t.battery_mv = 16'($urandom);
        else
            t.battery_mv = 16'($urandom_range(int'(cfg_low_bat), 65535));
        return t;
    endfunction

    function automatic in_item_t noise_tick();
        logic [95:0] raw;
        in_item_t    t;
        raw = {$urandom, $urandom, $urandom};
        t = raw[$bits(in_item_t)-1:0];
        return t;
    endfunction

    function automatic out_item_t typed_out(logic [2:0] st, logic trig,
                                            logic [3:0] ev0, logic [3:0] ev1);
        out_item_t r;
        r.drive_one      = 1'b0;
        r.drive_two      = 1'b0;
        r.sample_trigger = trig;
        r.device_status  = st;
        r.first_event    = ev0;
        r.second_event   = ev1;
        return r;
    endfunction

    typedef struct {
        in_item_t  t;
        bit        typed;
        out_item_t want;
    } tick_row_t;

    initial
    begin
        tick_row_t  rows [$];
        tick_row_t  row;
        in_item_t   t;
        out_item_t  none;
        int         phase;
        int         len;
        logic [1:0] mode;
        logic [31:0] target;
        logic [15:0] low_bat;
        logic [7:0]  puff_deb;
        logic [12:0] det_deb;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        items_sent    = 0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        none          = '0;
        predictor_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset a puff with the channels not ready leaves the
        // block idle and gives an event-free beat, without touching the
        // detect debounce.
        t = make_tick(1'b1, 1'b0, 1'b1, 1'b1);
        send_tick(t, 1'b1, typed_out(ST_IDLE, 1'b0, EV_NONE, EV_NONE));
        drain();

        // Short debounce lengths and the widest target for the directed walk.
        write_all(MODE_ALT, 32'hFFFF_FFFF, 16'd3600, 8'd1, 13'd1);

        // Insert both heaters, then one puff through calibration, a low battery,
        // large energy, zero codes, the target reached and a removal.
        row.typed = 1'b1;
        row.t = make_tick(1'b0, 1'b0, 1'b0, 1'b0);
        row.want = typed_out(ST_IDLE, 1'b0, EV_ONE_IN, EV_TWO_IN);
        rows.push_back(row);
        row.want = typed_out(ST_IDLE, 1'b0, EV_NONE, EV_NONE);
        rows.push_back(row);
        row.t = make_tick(1'b1, 1'b1, 1'b1, 1'b1);
        row.want = typed_out(ST_HEATING, 1'b1, EV_CAL, EV_NONE);
        rows.push_back(row);
        row.t.battery_mv = 16'd0;
        row.want = typed_out(ST_LOW_BAT, 1'b0, EV_BAT_LOW, EV_NONE);
        rows.push_back(row);
        row.typed = 1'b0;
        rows.push_back(row);
        row.t.battery_mv = 16'hFFFF;
        rows.push_back(row);
        row.t.heater_one_mv  = 16'hFFFF;
        row.t.heater_one_res = 16'd1;
        rows.push_back(row);
        row.t.heater_one_mv  = 16'd0;
        rows.push_back(row);
        row.t.heater_one_mv  = 16'hFFFF;
        row.t.heater_one_res = 16'd0;
        rows.push_back(row);
        row.t.heater_one_res = 16'hFFFF;
        rows.push_back(row);
        row.t.detect_one_pin = 1'b0;
        rows.push_back(row);
        row.t.detect_one_pin = 1'b1;
        rows.push_back(row);
        row.t.channels_ready = 1'b0;
        rows.push_back(row);
        row.typed = 1'b1;
        row.t = make_tick(1'b0, 1'b0, 1'b1, 1'b1);
        row.want = typed_out(ST_OPEN, 1'b0, EV_ONE_OUT, EV_TWO_OUT);
        rows.push_back(row);
        row.typed = 1'b0;
        row.t = make_tick(1'b1, 1'b1, 1'b1, 1'b1);
        rows.push_back(row);
        row.t = make_tick(1'b1, 1'b0, 1'b0, 1'b0);
        rows.push_back(row);
        foreach (rows[i])
            send_tick(rows[i].t, rows[i].typed, rows[i].want);
        drain();

        // Random phases: each one picks a register setting (the first few
        // are the extremes), inserts heaters, runs a puff of random length
        // and sometimes removes a heater. A tenth of the later phases are
        // pure noise.
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            case (phase)
                0: write_all(MODE_ONE, 32'd0, 16'd0, 8'd255, 13'd1);
                1: write_all(MODE_TWO, 32'hFFFF_FFFF, 16'hFFFF, 8'd1, 13'd2);
                2: write_all(MODE_BOTH, 32'hFFFF_FFFF, 16'd0, 8'd3, 13'd1);
                3: write_all(MODE_ALT, 32'($urandom), 16'd3600, 8'd1, 13'd8191);
                default:
                begin
                    mode     = 2'($urandom);
                    target   = $urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 4000000);
                    low_bat  = 16'($urandom_range(0, 5000));
                    puff_deb = 8'($urandom_range(1, 6));
                    det_deb  = 13'($urandom_range(1, 6));
                    write_all(mode, target, low_bat, puff_deb, det_deb);
                end
            endcase
            no_idle = ($urandom_range(0, 3) == 0);

            if (phase > 6 && $urandom_range(0, 9) == 0)
            begin
                for (int i = 0; i < 30; i++)
                    send_tick(noise_tick(), 1'b0, none);
            end
            else
            begin
                // Insertion: pins mostly low, capped for the very long debounce.
                len = int'(cfg_detect_deb) + $urandom_range(0, 2);
                if (len > 40)
                    len = 40;
                for (int i = 0; i < len; i++)
                    send_tick(make_tick(1'b0, 1'($urandom_range(0, 1)),
                                        $urandom_range(0, 9) == 0,
                                        $urandom_range(0, 9) == 0), 1'b0, none);
                // The puff: up to three heated frames with the odd short or
                // dropped ready. One puff has the receiver hold off at its start.
                len = $urandom_range(5, 230);
                for (int i = 0; i < len; i++)
                begin
                    if (phase == 6 && i == 0)
                        long_hold_req = 1'b1;
                    send_tick(make_tick(1'b1, $urandom_range(0, 19) != 0,
                                        $urandom_range(0, 59) != 0,
                                        $urandom_range(0, 59) != 0), 1'b0, none);
                end
                // Sometimes pull a heater out afterwards.
                if ($urandom_range(0, 2) == 0)
                begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_tick(make_tick(1'b0, 1'b0, 1'($urandom_range(0, 1)), 1'b1),
                                  1'b0, none);
                end
            end
            drain();
            phase++;
        end

        drain();
        repeat (50) @(posedge clk);
        $display("%0d tick beats over %0d register settings, %0d results checked",
                 items_sent, phase + 2, checked);
        $display("%0d calibrations and %0d frames that reached their target",
                 cal_seen, reached_seen);
        if (mismatches == 0 && due_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/hefc_pkg.sv
sv/heater_energy_frame_controller.sv
tb/tb_heater_energy_frame_controller.sv
